// File: rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants, region codes and width helpers for the point to segment
// distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int NORM_WIDTH      = 64;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [1:0] REGION_START = 2'd0;
  localparam logic [1:0] REGION_END   = 2'd1;
  localparam logic [1:0] REGION_FOOT  = 2'd2;

  // Width of one classified request as it travels from the front to the back.
  function automatic int item_width(int cw);
    return 2 + 2 * (2 * cw + 1) + 4 * (cw + 1);
  endfunction

endpackage

// File: rtl/core/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Accepts requests, forms the difference vectors, the dot product and the
// squared segment length, and classifies each request by region.
// ----------------------------------------------------------------------------
module psd_front
  import psd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int CW = COORD_WIDTH,
  localparam int EW = CW + 1,
  localparam int LW = 2 * CW + 1,
  localparam int ItemWidth = item_width(CW)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [CW-1:0] point_x_i,
  input  logic signed [CW-1:0] point_y_i,
  input  logic signed [CW-1:0] start_x_i,
  input  logic signed [CW-1:0] start_y_i,
  input  logic signed [CW-1:0] end_x_i,
  input  logic signed [CW-1:0] end_y_i,
  output logic                 push_o,
  input  logic                 full_i,
  output logic [ItemWidth-1:0] item_o
);

  typedef struct packed {
    logic [1:0]           region;
    logic [LW-1:0]        dot;
    logic [LW-1:0]        len2;
    logic signed [EW-1:0] ex;
    logic signed [EW-1:0] ey;
    logic signed [EW-1:0] vx;
    logic signed [EW-1:0] vy;
  } item_t;

  typedef struct packed {
    logic signed [EW-1:0] dx;
    logic signed [EW-1:0] dy;
    logic signed [EW-1:0] ex;
    logic signed [EW-1:0] ey;
    logic signed [EW-1:0] gx;
    logic signed [EW-1:0] gy;
  } diff_t;

  logic adv;
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  diff_t s1_q, s2_q, s3_q;
  logic signed [2*EW-1:0] pdx_q, pdy_q, lx_q, ly_q;
  logic signed [2*EW:0] dot_q;
  logic [LW-1:0] len2_q;
  logic dot_le_zero, dot_ge_len;
  item_t item_d, item_q;

  assign adv        = !(s4_vld_q && full_i);
  assign in_stall_o = !adv;
  assign push_o     = s4_vld_q && !full_i;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  assign dot_le_zero = dot_q[2*EW] || (dot_q == '0);
  assign dot_ge_len  = $unsigned(dot_q) >= {2'b00, len2_q};

  always_comb begin
    item_d.dot  = dot_q[LW-1:0];
    item_d.len2 = len2_q;
    item_d.ex   = s3_q.ex;
    item_d.ey   = s3_q.ey;
    item_d.vx   = s3_q.dx;
    item_d.vy   = s3_q.dy;
    if (dot_le_zero) begin
      item_d.region = REGION_START;
    end else if (dot_ge_len) begin
      item_d.region = REGION_END;
      item_d.vx     = s3_q.gx;
      item_d.vy     = s3_q.gy;
    end else begin
      item_d.region = REGION_FOOT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.dx <= {point_x_i[CW-1], point_x_i} - {start_x_i[CW-1], start_x_i};
      s1_q.dy <= {point_y_i[CW-1], point_y_i} - {start_y_i[CW-1], start_y_i};
      s1_q.ex <= {end_x_i[CW-1], end_x_i} - {start_x_i[CW-1], start_x_i};
      s1_q.ey <= {end_y_i[CW-1], end_y_i} - {start_y_i[CW-1], start_y_i};
      s1_q.gx <= {point_x_i[CW-1], point_x_i} - {end_x_i[CW-1], end_x_i};
      s1_q.gy <= {point_y_i[CW-1], point_y_i} - {end_y_i[CW-1], end_y_i};
      s2_q    <= s1_q;
      pdx_q   <= s1_q.ex * s1_q.dx;
      pdy_q   <= s1_q.ey * s1_q.dy;
      lx_q    <= s1_q.ex * s1_q.ex;
      ly_q    <= s1_q.ey * s1_q.ey;
      s3_q    <= s2_q;
      dot_q   <= {pdx_q[2*EW-1], pdx_q} + {pdy_q[2*EW-1], pdy_q};
      len2_q  <= lx_q[LW-1:0] + ly_q[LW-1:0];
      item_q  <= item_d;
    end
  end

endmodule

// File: rtl/core/psd_queue.sv
// ----------------------------------------------------------------------------
// psd_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module psd_queue
  import psd_pkg::*;
#(
  parameter int WIDTH = item_width(COORD_WIDTH_DEF),
  localparam int PW = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0] cnt_q;

  assign full_o  = cnt_q == (PW + 1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not follow a write");

endmodule

// File: rtl/core/psd_root.sv
// ----------------------------------------------------------------------------
// psd_root
// Pipelined square root, one result bit per stage, rounded to nearest and
// saturated to the distance width, followed by the output register.
// ----------------------------------------------------------------------------
module psd_root
  import psd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int RW = COORD_WIDTH + 2,
  localparam int RMW = RW + 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            in_valid_i,
  input  logic [1:0]      region_i,
  input  logic [2*RW-1:0] value_i,
  output logic            out_valid_o,
  output logic [RW-1:0]   distance_o,
  output logic [1:0]      region_o
);

  typedef struct packed {
    logic [1:0]      region;
    logic [RMW-1:0]  rem;
    logic [RW-1:0]   root;
    logic [2*RW-1:0] val;
  } root_t;

  function automatic root_t root_step(root_t s);
    root_t n;
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    n     = s;
    t     = {s.rem, s.val[2*RW-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    n.val = {s.val[2*RW-3:0], 2'b00};
    if (t >= trial) begin
      n.rem  = RMW'(t - trial);
      n.root = {s.root[RW-2:0], 1'b1};
    end else begin
      n.rem  = RMW'(t);
      n.root = {s.root[RW-2:0], 1'b0};
    end
    return n;
  endfunction

  root_t st_q [RW+1];
  logic [RW:0] vld_q;
  logic out_vld_q;
  logic [RW-1:0] dist_q;
  logic [1:0] reg_q;
  logic round_up;
  logic [RW:0] rounded;

  assign out_valid_o = out_vld_q;
  assign distance_o  = dist_q;
  assign region_o    = reg_q;

  assign round_up = st_q[RW].rem > RMW'(st_q[RW].root);
  assign rounded  = {1'b0, st_q[RW].root} + (RW + 1)'(round_up);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q     <= {vld_q[RW-1:0], in_valid_i};
      out_vld_q <= vld_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q[0].region <= region_i;
      st_q[0].rem    <= '0;
      st_q[0].root   <= '0;
      st_q[0].val    <= value_i;
      dist_q         <= rounded[RW] ? '1 : rounded[RW-1:0];
      reg_q          <= st_q[RW].region;
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[j+1] <= root_step(st_q[j]);
      end
    end
  end

endmodule

// File: rtl/core/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Carries out classified requests: normalizes the projection ratio, forms the
// foot offset with a pipelined divider, squares the remaining vector and
// hands the squared distance to the square root pipeline.
// ----------------------------------------------------------------------------
module psd_back
  import psd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int CW = COORD_WIDTH,
  localparam int EW = CW + 1,
  localparam int LW = 2 * CW + 1,
  localparam int NW = (LW > NORM_WIDTH) ? NORM_WIDTH : LW,
  localparam int XB = LW - NW,
  localparam int HW = (NW + 1) / 2,
  localparam int HHW = NW - HW,
  localparam int NUMW = CW + NW,
  localparam int SW = 2 * EW + 1,
  localparam int RW = CW + 2,
  localparam int ItemWidth = item_width(CW)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  logic [ItemWidth-1:0] item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [RW-1:0]        distance_o,
  output logic [1:0]           region_o
);

  typedef struct packed {
    logic [1:0]           region;
    logic [LW-1:0]        dot;
    logic [LW-1:0]        len2;
    logic signed [EW-1:0] ex;
    logic signed [EW-1:0] ey;
    logic signed [EW-1:0] vx;
    logic signed [EW-1:0] vy;
  } item_t;

  typedef struct packed {
    logic [1:0]           region;
    logic [NW-1:0]        dn;
    logic [NW-1:0]        ln;
    logic signed [EW-1:0] ex;
    logic signed [EW-1:0] ey;
    logic signed [EW-1:0] vx;
    logic signed [EW-1:0] vy;
  } nrm_t;

  typedef struct packed {
    logic [1:0]           region;
    logic                 sx;
    logic                 sy;
    logic [NW-1:0]        ln;
    logic [CW+HW-1:0]     xl;
    logic [CW+HHW-1:0]    xh;
    logic [CW+HW-1:0]     yl;
    logic [CW+HHW-1:0]    yh;
    logic signed [EW-1:0] vx;
    logic signed [EW-1:0] vy;
  } mul_t;

  typedef struct packed {
    logic [1:0]           region;
    logic                 sx;
    logic                 sy;
    logic [NW-1:0]        ln;
    logic [NW-1:0]        rx;
    logic [NW-1:0]        ry;
    logic [CW-1:0]        lx;
    logic [CW-1:0]        ly;
    logic signed [EW-1:0] vx;
    logic signed [EW-1:0] vy;
  } div_t;

  function automatic logic [NW+CW-1:0] div_step(logic [NW-1:0] r, logic [CW-1:0] l,
                                                logic [NW-1:0] d);
    logic [NW:0] t;
    logic [NW:0] diff;
    t    = {r, l[CW-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {diff[NW-1:0], l[CW-2:0], 1'b1};
    end else begin
      return {t[NW-1:0], l[CW-2:0], 1'b0};
    end
  endfunction

  function automatic div_t div_next(div_t s);
    div_t n;
    n = s;
    {n.rx, n.lx} = div_step(s.rx, s.lx, s.ln);
    {n.ry, n.ly} = div_step(s.ry, s.ly, s.ln);
    return n;
  endfunction

  item_t it;
  logic adv;
  logic n_vld_q, m_vld_q, s_vld_q, p_vld_q, q_vld_q;
  logic [CW:0] d_vld_q;
  logic [NW-1:0] dn, ln;
  nrm_t n_q;
  mul_t m_q;
  div_t d_q [CW+1];
  div_t d_first;
  logic [CW-1:0] mag_ex, mag_ey;
  logic [NUMW-1:0] num_x, num_y;
  logic signed [EW-1:0] fx, fy;
  logic signed [EW:0] wx_q, wy_q;
  logic [1:0] s_reg_q, p_reg_q, q_reg_q;
  logic [EW-1:0] mag_wx, mag_wy;
  logic [2*EW-1:0] sqx_q, sqy_q;
  logic [SW-1:0] sum_q;

  assign it    = item_i;
  assign adv   = !out_valid_o || !out_stall_i;
  assign pop_o = adv && !empty_i;

  if (XB > 0) begin : g_norm
    logic [$clog2(XB + 1)-1:0] nk;
    always_comb begin
      nk = '0;
      for (int i = 0; i < XB; i++) begin
        if (it.len2[NW+i]) begin
          nk = ($clog2(XB + 1))'(i + 1);
        end
      end
    end
    assign dn = NW'(it.dot >> nk);
    assign ln = NW'(it.len2 >> nk);
  end else begin : g_nonorm
    assign dn = it.dot;
    assign ln = it.len2;
  end

  assign mag_ex = n_q.ex[EW-1] ? CW'(-n_q.ex) : CW'(n_q.ex);
  assign mag_ey = n_q.ey[EW-1] ? CW'(-n_q.ey) : CW'(n_q.ey);

  assign num_x = (NUMW'(m_q.xh) << HW) + NUMW'(m_q.xl) + NUMW'(m_q.ln >> 1);
  assign num_y = (NUMW'(m_q.yh) << HW) + NUMW'(m_q.yl) + NUMW'(m_q.ln >> 1);

  always_comb begin
    d_first.region = m_q.region;
    d_first.sx     = m_q.sx;
    d_first.sy     = m_q.sy;
    d_first.ln     = m_q.ln;
    d_first.rx     = num_x[NUMW-1:CW];
    d_first.ry     = num_y[NUMW-1:CW];
    d_first.lx     = num_x[CW-1:0];
    d_first.ly     = num_y[CW-1:0];
    d_first.vx     = m_q.vx;
    d_first.vy     = m_q.vy;
  end

  always_comb begin
    fx = '0;
    fy = '0;
    if (d_q[CW].region == REGION_FOOT) begin
      fx = d_q[CW].sx ? -$signed({1'b0, d_q[CW].lx}) : $signed({1'b0, d_q[CW].lx});
      fy = d_q[CW].sy ? -$signed({1'b0, d_q[CW].ly}) : $signed({1'b0, d_q[CW].ly});
    end
  end

  assign mag_wx = wx_q[EW] ? EW'(-wx_q) : EW'(wx_q);
  assign mag_wy = wy_q[EW] ? EW'(-wy_q) : EW'(wy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      d_vld_q <= '0;
      s_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      q_vld_q <= 1'b0;
    end else if (adv) begin
      n_vld_q <= !empty_i;
      m_vld_q <= n_vld_q;
      d_vld_q <= {d_vld_q[CW-1:0], m_vld_q};
      s_vld_q <= d_vld_q[CW];
      p_vld_q <= s_vld_q;
      q_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_q.region <= it.region;
      n_q.dn     <= dn;
      n_q.ln     <= ln;
      n_q.ex     <= it.ex;
      n_q.ey     <= it.ey;
      n_q.vx     <= it.vx;
      n_q.vy     <= it.vy;
      m_q.region <= n_q.region;
      m_q.sx     <= n_q.ex[EW-1];
      m_q.sy     <= n_q.ey[EW-1];
      m_q.ln     <= n_q.ln;
      m_q.xl     <= mag_ex * n_q.dn[HW-1:0];
      m_q.xh     <= mag_ex * n_q.dn[NW-1:HW];
      m_q.yl     <= mag_ey * n_q.dn[HW-1:0];
      m_q.yh     <= mag_ey * n_q.dn[NW-1:HW];
      m_q.vx     <= n_q.vx;
      m_q.vy     <= n_q.vy;
      d_q[0]     <= d_first;
      wx_q       <= {d_q[CW].vx[EW-1], d_q[CW].vx} - {fx[EW-1], fx};
      wy_q       <= {d_q[CW].vy[EW-1], d_q[CW].vy} - {fy[EW-1], fy};
      s_reg_q    <= d_q[CW].region;
      sqx_q      <= mag_wx * mag_wx;
      sqy_q      <= mag_wy * mag_wy;
      p_reg_q    <= s_reg_q;
      sum_q      <= {1'b0, sqx_q} + {1'b0, sqy_q};
      q_reg_q    <= p_reg_q;
    end
  end

  for (genvar j = 0; j < CW; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d_q[j+1] <= div_next(d_q[j]);
      end
    end
  end

  psd_root #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (q_vld_q),
    .region_i   (q_reg_q),
    .value_i    ({1'b0, sum_q}),
    .out_valid_o(out_valid_o),
    .distance_o (distance_o),
    .region_o   (region_o)
  );

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(d_vld_q)) else $error("divider moved while output stalled");

endmodule

// File: rtl/core/point_segment_distance.sv
// ----------------------------------------------------------------------------
// point_segment_distance
// Euclidean distance from a point to a 2D line segment, signed fixed-point
// coordinates in, saturating unsigned distance and deciding region out.
//
//   Channel  Direction  Handshake                Payload
//   input    in         in_valid_i / in_stall_o  point, start, end (x, y)
//   output   out        out_valid_o / out_stall_i distance, region
//
// One request is taken per cycle and one result leaves per cycle while neither side is stalled.
// The back part holds the bit-serial divider and square root pipelines.
// Reset clears all valid flags and the queue; no clearing pass is needed.
// The front stalls only when the queue is full; the back stalls only when a
// result waits in the output register and the output is stalled.
// ----------------------------------------------------------------------------
module point_segment_distance
  import psd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int ItemWidth = item_width(COORD_WIDTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [COORD_WIDTH+1:0]        distance_o,
  output logic [1:0]                    region_o
);

  logic push, full, pop, empty;
  logic [ItemWidth-1:0] push_item, head_item;

  psd_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .push_o    (push),
    .full_i    (full),
    .item_o    (push_item)
  );

  psd_queue #(
    .WIDTH(ItemWidth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (head_item)
  );

  psd_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .item_i     (head_item),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .distance_o (distance_o),
    .region_o   (region_o)
  );

endmodule

// File: verif/point_segment_distance_tb.sv
// ----------------------------------------------------------------------------
// point_segment_distance_tb
// Drives point and segment requests into the distance block under varying
// sender and receiver idling, predicts each distance and region in the
// scoreboard, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_segment_distance_tb;
  import psd_pkg::*;

  localparam int CW = 32;
  localparam int OW = CW + 2;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    logic signed [CW-1:0] px, py, sx, sy, qx, qy;
  } seg_req_t;

  typedef struct {
    logic [OW-1:0] distance;
    logic [1:0]    region;
  } dist_res_t;

  class distance_scoreboard;
    dist_res_t expected_q[$];
    int        errors = 0;

    function automatic logic [OW-1:0] round_root(logic [127:0] v);
      logic [127:0] r, c, rem;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= v) r = c;
      end
      rem = v - r * r;
      if (rem > r) r = r + 1;
      if (r > {{(128-OW){1'b0}}, {OW{1'b1}}}) r = {{(128-OW){1'b0}}, {OW{1'b1}}};
      return r[OW-1:0];
    endfunction

    function automatic logic signed [127:0] foot_offset(logic signed [127:0] e,
                                                        logic [127:0] dn,
                                                        logic [127:0] ln);
      logic [127:0] num, q;
      num = (e < 0 ? -e : e) * dn + (ln >> 1);
      q = {64'd0, 64'(num / ln)};
      return e < 0 ? -$signed(q) : $signed(q);
    endfunction

    function void note(seg_req_t r);
      logic signed [127:0] dx, dy, ex, ey, dot, fx, fy;
      logic [127:0] len2, dn, ln;
      int nb, k;
      dist_res_t res;
      dx = 128'(r.px) - 128'(r.sx);
      dy = 128'(r.py) - 128'(r.sy);
      ex = 128'(r.qx) - 128'(r.sx);
      ey = 128'(r.qy) - 128'(r.sy);
      dot = ex * dx + ey * dy;
      len2 = ex * ex + ey * ey;
      if (dot <= 0) begin
        res.region = REGION_START;
        res.distance = round_root(dx * dx + dy * dy);
      end else if ($unsigned(dot) >= len2) begin
        res.region = REGION_END;
        fx = 128'(r.px) - 128'(r.qx);
        fy = 128'(r.py) - 128'(r.qy);
        res.distance = round_root(fx * fx + fy * fy);
      end else begin
        res.region = REGION_FOOT;
        nb = 0;
        for (int i = 0; i < 128; i++) if (len2[i]) nb = i + 1;
        k = nb > 64 ? nb - 64 : 0;
        dn = {64'd0, 64'($unsigned(dot) >> k)};
        ln = {64'd0, 64'(len2 >> k)};
        fx = dx - foot_offset(ex, dn, ln);
        fy = dy - foot_offset(ey, dn, ln);
        res.distance = round_root(fx * fx + fy * fy);
      end
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(logic [OW-1:0] distance, logic [1:0] region);
      dist_res_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result distance=%0h region=%0d", distance, region));
        return;
      end
      e = expected_q.pop_front();
      if (distance !== e.distance)
        report($sformatf("distance got %0h expected %0h", distance, e.distance));
      if (region !== e.region)
        report($sformatf("region got %0d expected %0d", region, e.region));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] point_x_i = '0, point_y_i = '0, start_x_i = '0;
  logic signed [CW-1:0] start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [OW-1:0] distance_o;
  logic [1:0] region_o;

  distance_scoreboard sb = new();
  int tx_idle_pct = 17;
  int rx_idle_pct = 65;
  int hold_cycles = 0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  point_segment_distance DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o)
      sb.note('{point_x_i, point_y_i, start_x_i, start_y_i, end_x_i, end_y_i});
    if (out_valid_o && !out_stall_i) sb.check(distance_o, region_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("point_segment_distance_tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cycles = 300;
      hold_req = 1'b0;
    end
    if (hold_cycles > 0) begin
      out_stall_i = 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  task send(seg_req_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    {point_x_i, point_y_i, start_x_i, start_y_i, end_x_i, end_y_i} =
      {r.px, r.py, r.sx, r.sy, r.qx, r.qy};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic signed [CW-1:0] pick_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed(CW'($urandom_range(0, 2000))) - 1000;
      default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  task send_random();
    seg_req_t r;
    int kind;
    kind = $urandom_range(0, 9);
    kind = kind < 4 ? 0 : (kind < 9 ? 1 : 2);
    r.px = pick_coord(kind);
    r.py = pick_coord(kind);
    r.sx = pick_coord(kind);
    r.sy = pick_coord(kind);
    r.qx = pick_coord(kind);
    r.qy = pick_coord(kind);
    send(r);
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  localparam logic signed [CW-1:0] MAXC = 32'sh7fffffff;
  localparam logic signed [CW-1:0] MINC = 32'sh80000000;
  localparam logic signed [CW-1:0] ONE  = 32'sh00010000;

  initial begin
    seg_req_t directed[$];
    directed = '{
      '{0, 0, 0, 0, 0, 0},
      '{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC},
      '{MINC, MINC, MINC, MINC, MINC, MINC},
      '{MAXC, MAXC, MINC, MINC, MINC, MINC},
      '{MINC, MAXC, MAXC, MINC, MAXC, MINC},
      '{0, 0, MINC, MINC, MAXC, MAXC},
      '{MAXC, MINC, MINC, MINC, MAXC, MAXC},
      '{MINC, MAXC, MINC, MINC, MAXC, MAXC},
      '{3 * ONE, 4 * ONE, 0, 0, 0, 0},
      '{0, 0, 0, 0, 10 * ONE, 0},
      '{10 * ONE, 0, 0, 0, 10 * ONE, 0},
      '{-ONE, ONE, 0, 0, 10 * ONE, 0},
      '{12 * ONE, -ONE, 0, 0, 10 * ONE, 0},
      '{5 * ONE, 3 * ONE, 0, 0, 10 * ONE, 0},
      '{ONE, 2 * ONE, -ONE, -ONE, 7 * ONE, 3 * ONE},
      '{-5 * ONE, 5 * ONE, 0, 0, -9 * ONE, 7 * ONE},
      '{7, -3, 1, 1, 13, 5},
      '{32'sh0000ffff, 32'sh5555aaaa, 32'shaaaa5555, 32'sh00000001, 32'sh12345678,
        32'shfedcba98},
      '{MAXC, 0, MINC, 0, MAXC, 0},
      '{0, MAXC, 0, MINC, 0, MAXC}
    };
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send(directed[i]);
    repeat (160) send_random();
    wait_drained();

    tx_idle_pct = 65;
    rx_idle_pct = 17;
    repeat (160) send_random();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (170) send_random();

    wait_drained();
    repeat (200) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("point_segment_distance_tb: PASS");
    end else begin
      $display("point_segment_distance_tb: FAIL");
    end
    $finish;
  end

endmodule
